/* rtl/ioc_pkg.sv */
`timescale 1ns / 1ps

package ioc_pkg;

  localparam int WINDOW_DEPTH = 16;
  localparam int IDX_W        = $clog2(WINDOW_DEPTH);
  localparam int SEQ_W        = 16;
  localparam int PAY_W        = 32;

  typedef logic [IDX_W-1:0] slot_idx_t;
  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [PAY_W-1:0] pay_t;

endpackage

/* rtl/in_order_completion_reorder_unit.sv */
`timescale 1ns / 1ps

// In-order completion reorder unit.
// Input channel: in_sequence_id / in_payload, one completion per beat.
// Output channel: released handles in sequence order; out_last marks the
// final beat caused by one input, out_rejected flags an input whose sequence
// lies outside the window (one beat, last set, input payload echoed).
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Per input: a rejected input is loaded straight into the output register.
// A stored input is written to its slot, then the head slot is read from the
// single-read-port, registered-read slot memory, then beats are released one
// per cycle while the output is not stalled, ending when the next slot is
// empty; an empty head slot releases nothing. Input is stalled meanwhile.
// The final beat of an input sits in the output register while the next
// input is accepted. A stall on the output holds the output register and
// pauses the release walk; input is stalled until the output register frees.
// Reset clears all slot valid bits, the head slot and the expected sequence;
// no clearing pass is needed, and input is accepted the cycle after reset.
module in_order_completion_reorder_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ioc_pkg::seq_t         in_sequence_id,
  input  ioc_pkg::pay_t         in_payload,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ioc_pkg::pay_t         out_payload,
  output ioc_pkg::seq_t         out_sequence,
  output logic                  out_last,
  output logic                  out_rejected
);
  import ioc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [WINDOW_DEPTH-1:0] valid_r, valid_nxt;
  slot_idx_t               head_r, head_nxt;
  seq_t                    ne_r, ne_nxt;

  pay_t                    mem [WINDOW_DEPTH];
  pay_t                    rd_data_r;
  slot_idx_t               rd_addr;
  logic                    wr_en;
  slot_idx_t               wr_idx;

  logic                    out_valid_r;
  pay_t                    out_payload_r;
  seq_t                    out_sequence_r;
  logic                    out_last_r;
  logic                    out_rejected_r;

  logic                    out_free;
  logic                    in_fire;
  seq_t                    offset;
  logic                    in_window;
  logic [IDX_W:0]          idx_sum;
  slot_idx_t               head_inc;
  logic                    emit_fire;
  logic                    load_out;
  pay_t                    load_payload;
  seq_t                    load_sequence;
  logic                    load_last;
  logic                    load_rejected;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_fire   = in_valid && !in_stall;
  assign offset    = in_sequence_id - ne_r;
  assign in_window = offset < SEQ_W'(WINDOW_DEPTH);
  assign idx_sum   = (IDX_W+1)'(head_r) + (IDX_W+1)'(offset[IDX_W-1:0]);
  assign head_inc  = (head_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign emit_fire = (state_r == S_EMIT) && out_free;
  assign wr_en     = in_fire && in_window;
  assign rd_addr   = emit_fire ? head_inc : head_r;

  always_comb begin
    if (idx_sum >= (IDX_W+1)'(WINDOW_DEPTH)) begin
      wr_idx = IDX_W'(idx_sum - (IDX_W+1)'(WINDOW_DEPTH));
    end else begin
      wr_idx = idx_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    head_nxt      = head_r;
    ne_nxt        = ne_r;
    load_out      = 1'b0;
    load_payload  = rd_data_r;
    load_sequence = ne_r;
    load_last     = 1'b0;
    load_rejected = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_window) begin
            valid_nxt[wr_idx] = 1'b1;
            state_nxt         = S_READ;
          end else begin
            load_out      = 1'b1;
            load_payload  = in_payload;
            load_sequence = in_sequence_id;
            load_last     = 1'b1;
            load_rejected = 1'b1;
          end
        end
      end
      S_READ: begin
        state_nxt = valid_r[head_r] ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (emit_fire) begin
          load_out          = 1'b1;
          load_last         = !valid_r[head_inc];
          valid_nxt[head_r] = 1'b0;
          head_nxt          = head_inc;
          ne_nxt            = ne_r + 1'b1;
          if (!valid_r[head_inc]) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= in_payload;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      head_r  <= '0;
      ne_r    <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      head_r  <= head_nxt;
      ne_r    <= ne_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_payload_r  <= load_payload;
      out_sequence_r <= load_sequence;
      out_last_r     <= load_last;
      out_rejected_r <= load_rejected;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_payload  = out_payload_r;
  assign out_sequence = out_sequence_r;
  assign out_last     = out_last_r;
  assign out_rejected = out_rejected_r;

  a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rejected_r) |-> out_last_r)
    else $error("rejected beat without last");

  a_emit_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> valid_r[head_r])
    else $error("release walk on an empty head slot");

  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (ne_r == $past(ne_r) + 1'b1) && !valid_r[$past(head_r)])
    else $error("release did not advance the window");

endmodule
